@@ src/mhpe_pkg.sv @@
// Shared types, sizes and result codes for the max-heap priority extract block.
// No dependencies; every other file refers to this package by scoped names.
package mhpe_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = IDX_W + 2;
    localparam int REC_W    = 32;
    localparam int OUT_W    = ((REC_W + CNT_W + 7) / 8) * 8;

    localparam logic [1:0] ST_LOADED    = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EXTRACTED = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_EXTRACT = 1'b1;

    // Packed so that the identifier sits in the lowest bits.
    typedef struct packed {
        logic [7:0]  urgency;
        logic [7:0]  age;
        logic [15:0] id;
    } rec_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] count;
        rec_t             rec;
    } res_t;

endpackage

@@ src/mhpe_engine.sv @@
// Heap sequencer: record store, shared urgency comparator and control steps.
// Depends on mhpe_pkg for sizes, record and result types and status codes.
module mhpe_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                req_type,
    input  mhpe_pkg::rec_t      req_rec,
    output logic                res_valid,
    input  logic                res_ready,
    output mhpe_pkg::res_t      res
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SIFT_RD = 4'd1;
    localparam logic [3:0] S_LOADN   = 4'd2;
    localparam logic [3:0] S_CHILD   = 4'd3;
    localparam logic [3:0] S_LEFT    = 4'd4;
    localparam logic [3:0] S_RIGHT   = 4'd5;
    localparam logic [3:0] S_SWAP_A  = 4'd6;
    localparam logic [3:0] S_SWAP_B  = 4'd7;
    localparam logic [3:0] S_ROOT_RD = 4'd8;
    localparam logic [3:0] S_ROOT    = 4'd9;
    localparam logic [3:0] S_LAST    = 4'd10;
    localparam logic [3:0] S_RESULT  = 4'd11;

    logic [3:0]                    state_reg, state_next;
    logic [mhpe_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [mhpe_pkg::IDX_W-1:0]    i_reg, i_next;
    logic [mhpe_pkg::IDX_W-1:0]    node_reg, node_next;
    logic [mhpe_pkg::IDX_W-1:0]    best_idx_reg, best_idx_next;
    mhpe_pkg::rec_t                cur_reg, cur_next;
    mhpe_pkg::rec_t                best_reg, best_next;
    mhpe_pkg::res_t                res_reg, res_next;

    mhpe_pkg::rec_t                mem [mhpe_pkg::CAPACITY];
    mhpe_pkg::rec_t                rd_data_reg;
    logic [mhpe_pkg::IDX_W-1:0]    rd_addr;
    logic                          wr_en;
    logic [mhpe_pkg::IDX_W-1:0]    wr_addr;
    mhpe_pkg::rec_t                wr_data;

    logic [mhpe_pkg::CHILD_W-1:0]  left_idx, right_idx, count_ext;
    logic                          left_ok, right_ok, child_wins;
    logic [mhpe_pkg::CNT_W-1:0]    first_parent;

    assign left_idx  = mhpe_pkg::CHILD_W'({node_reg, 1'b1});
    assign right_idx = left_idx + mhpe_pkg::CHILD_W'(1);
    assign count_ext = mhpe_pkg::CHILD_W'(count_reg);
    assign left_ok   = left_idx < count_ext;
    assign right_ok  = right_idx < count_ext;
    // The one comparator: a child replaces the current best only when strictly more urgent.
    assign child_wins   = best_reg.urgency < rd_data_reg.urgency;
    assign first_parent = (count_reg - mhpe_pkg::CNT_W'(2)) >> 1;

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESULT);
    assign res       = res_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        i_next        = i_reg;
        node_next     = node_reg;
        best_idx_next = best_idx_reg;
        cur_next      = cur_reg;
        best_next     = best_reg;
        res_next      = res_reg;
        rd_addr       = node_reg;
        wr_en         = 1'b0;
        wr_addr       = node_reg;
        wr_data       = best_reg;

        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    res_next.rec   = '0;
                    res_next.count = count_reg;
                    if (req_type == mhpe_pkg::REQ_LOAD) begin
                        if (count_reg == mhpe_pkg::CNT_W'(mhpe_pkg::CAPACITY)) begin
                            res_next.status = mhpe_pkg::ST_FULL;
                        end else begin
                            wr_en           = 1'b1;
                            wr_addr         = count_reg[mhpe_pkg::IDX_W-1:0];
                            wr_data         = req_rec;
                            count_next      = count_reg + mhpe_pkg::CNT_W'(1);
                            res_next.count  = count_next;
                            res_next.status = mhpe_pkg::ST_LOADED;
                        end
                        state_next = S_RESULT;
                    end else if (count_reg == '0) begin
                        res_next.status = mhpe_pkg::ST_EMPTY;
                        state_next      = S_RESULT;
                    end else if (count_reg == mhpe_pkg::CNT_W'(1)) begin
                        state_next = S_ROOT_RD;
                    end else begin
                        i_next     = first_parent[mhpe_pkg::IDX_W-1:0];
                        node_next  = first_parent[mhpe_pkg::IDX_W-1:0];
                        state_next = S_SIFT_RD;
                    end
                end
            end
            S_SIFT_RD: begin
                rd_addr    = node_reg;
                state_next = S_LOADN;
            end
            S_LOADN: begin
                cur_next      = rd_data_reg;
                best_next     = rd_data_reg;
                best_idx_next = node_reg;
                state_next    = S_CHILD;
            end
            S_CHILD: begin
                if (left_ok) begin
                    rd_addr    = left_idx[mhpe_pkg::IDX_W-1:0];
                    state_next = S_LEFT;
                end else if (i_reg == '0) begin
                    state_next = S_ROOT_RD;
                end else begin
                    i_next     = i_reg - mhpe_pkg::IDX_W'(1);
                    node_next  = i_reg - mhpe_pkg::IDX_W'(1);
                    state_next = S_SIFT_RD;
                end
            end
            S_LEFT: begin
                if (child_wins) begin
                    best_next     = rd_data_reg;
                    best_idx_next = left_idx[mhpe_pkg::IDX_W-1:0];
                end
                if (right_ok) begin
                    rd_addr    = right_idx[mhpe_pkg::IDX_W-1:0];
                    state_next = S_RIGHT;
                end else begin
                    state_next = S_SWAP_A;
                end
            end
            S_RIGHT: begin
                if (child_wins) begin
                    best_next     = rd_data_reg;
                    best_idx_next = right_idx[mhpe_pkg::IDX_W-1:0];
                end
                state_next = S_SWAP_A;
            end
            S_SWAP_A: begin
                if (best_idx_reg == node_reg) begin
                    // Parent already dominates: this sift-down is over.
                    if (i_reg == '0) begin
                        state_next = S_ROOT_RD;
                    end else begin
                        i_next     = i_reg - mhpe_pkg::IDX_W'(1);
                        node_next  = i_reg - mhpe_pkg::IDX_W'(1);
                        state_next = S_SIFT_RD;
                    end
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = node_reg;
                    wr_data    = best_reg;
                    state_next = S_SWAP_B;
                end
            end
            S_SWAP_B: begin
                wr_en      = 1'b1;
                wr_addr    = best_idx_reg;
                wr_data    = cur_reg;
                node_next  = best_idx_reg;
                best_next  = cur_reg;
                state_next = S_CHILD;
            end
            S_ROOT_RD: begin
                rd_addr    = '0;
                state_next = S_ROOT;
            end
            S_ROOT: begin
                res_next.rec    = rd_data_reg;
                res_next.status = mhpe_pkg::ST_EXTRACTED;
                rd_addr         = mhpe_pkg::IDX_W'(count_reg - mhpe_pkg::CNT_W'(1));
                state_next      = S_LAST;
            end
            S_LAST: begin
                wr_en          = 1'b1;
                wr_addr        = '0;
                wr_data        = rd_data_reg;
                count_next     = count_reg - mhpe_pkg::CNT_W'(1);
                res_next.count = count_next;
                state_next     = S_RESULT;
            end
            S_RESULT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        i_reg        <= i_next;
        node_reg     <= node_next;
        best_idx_reg <= best_idx_next;
        cur_reg      <= cur_next;
        best_reg     <= best_next;
        res_reg      <= res_next;
    end

endmodule

@@ src/max_heap_priority_extract_top.sv @@
// A load, a rejected load or an empty extract goes straight to its result. An extract
// from a store of one reads the root, then moves the last entry there. A larger extract
// first rebuilds the heap on one store read port and one comparator: each sift-down reads
// its node, then each child in turn, and a level that swaps writes both entries in turn.
// Throughput: one request at a time, the next taken once the result is in the output
// register. Synchronous active-low reset empties the store.
module max_heap_priority_extract_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // patient_id [15:0], age [23:16], urgency [31:24]
    input  logic [mhpe_pkg::REC_W-1:0] s_tdata,
    // req_type [0]
    input  logic [0:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // out_id [15:0], out_age [23:16], out_urgency [31:24], entry_count [36:32], zero above
    output logic [mhpe_pkg::OUT_W-1:0] m_tdata,
    // status [1:0]
    output logic [1:0]                 m_tuser
);

    logic                       eng_res_valid;
    logic                       eng_res_ready;
    mhpe_pkg::res_t             eng_res;

    logic                       m_tvalid_reg, m_tvalid_next;
    logic [mhpe_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]                 m_tuser_reg, m_tuser_next;

    // The engine walks the heap; this level only holds the finished result so that the
    // engine can take the next request while the result waits downstream.
    mhpe_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_type  (s_tuser[0]),
        .req_rec   (mhpe_pkg::rec_t'(s_tdata)),
        .res_valid (eng_res_valid),
        .res_ready (eng_res_ready),
        .res       (eng_res)
    );

    // The output register may be refilled in the same cycle that it is drained.
    assign eng_res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (eng_res_ready) begin
            m_tvalid_next = eng_res_valid;
            if (eng_res_valid) begin
                m_tdata_next = mhpe_pkg::OUT_W'({eng_res.count, eng_res.rec});
                m_tuser_next = eng_res.status;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ src/mhpe_checker.sv @@
// Port-level checks on the max-heap priority extract top level, and the bind that attaches them.
// Depends on mhpe_pkg for the widths, the status codes and the store capacity.
module mhpe_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [mhpe_pkg::OUT_W-1:0] m_tdata,
    input logic [1:0]                 m_tuser
);

    logic [mhpe_pkg::CNT_W-1:0] out_count;
    assign out_count = m_tdata[mhpe_pkg::REC_W +: mhpe_pkg::CNT_W];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_count <= mhpe_pkg::CNT_W'(mhpe_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == mhpe_pkg::ST_FULL
        |-> out_count == mhpe_pkg::CNT_W'(mhpe_pkg::CAPACITY)
            && m_tdata[mhpe_pkg::REC_W-1:0] == '0)
        else $error("full rejection with a store that is not full");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == mhpe_pkg::ST_EMPTY
        |-> out_count == '0 && m_tdata[mhpe_pkg::REC_W-1:0] == '0)
        else $error("empty report with records stored");

    a_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == mhpe_pkg::ST_LOADED
        |-> out_count != '0 && m_tdata[mhpe_pkg::REC_W-1:0] == '0)
        else $error("load result with no stored record");

endmodule

bind max_heap_priority_extract_top mhpe_checker u_mhpe_checker (.*);

@@ dv/max_heap_priority_extract_top_test.sv @@
// Self-checking testbench for the max-heap priority extract block, with a
// predictor of the heap inside. Needs mhpe_pkg and max_heap_priority_extract_top.
`timescale 1ns / 1ps

module max_heap_priority_extract_top_test;

    localparam int TOTAL_REQUESTS = 1550;
    // Time to wait after the last expected result before the report.
    localparam int SETTLE_CYCLES  = 160;
    // Watchdog limit, far above the length of the slowest correct run.
    localparam int CYCLE_LIMIT    = 1000000;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [mhpe_pkg::REC_W-1:0]   s_tdata;
    logic [0:0]                   s_tuser;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [mhpe_pkg::OUT_W-1:0]   m_tdata;
    logic [1:0]                   m_tuser;

    // Predictor state: the entry array in the order the block keeps it, and the
    // number of records that are stored.
    mhpe_pkg::rec_t     heap_model [mhpe_pkg::CAPACITY];
    int                 heap_fill;
    mhpe_pkg::res_t     expected_results [$];

    int                 mismatches;
    int                 results_seen;
    int                 requests_sent;
    int                 cycle_count;
    // When set, the matching side runs for a while with no idle cycles at all.
    bit                 feed_steady;
    bit                 sink_steady;

    max_heap_priority_extract_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Works out the result of one accepted request and updates the predicted
    // heap. An extract first rebuilds the heap bottom-up, sifting each node down
    // with strict compares, left child first, so equal urgencies never swap.
    function automatic mhpe_pkg::res_t predict_outcome(logic kind, mhpe_pkg::rec_t rec);
        mhpe_pkg::res_t outcome;
        mhpe_pkg::rec_t spare;
        int   top;
        int   node;
        int   best;
        int   left;
        bit   moving;
        outcome = '0;
        if (kind == mhpe_pkg::REQ_LOAD) begin
            if (heap_fill >= mhpe_pkg::CAPACITY) begin
                outcome.status = mhpe_pkg::ST_FULL;
            end else begin
                heap_model[heap_fill] = rec;
                heap_fill++;
                outcome.status = mhpe_pkg::ST_LOADED;
            end
        end else if (heap_fill == 0) begin
            outcome.status = mhpe_pkg::ST_EMPTY;
        end else begin
            if (heap_fill >= 2) begin
                for (top = (heap_fill - 2) / 2; top >= 0; top--) begin
                    node = top;
                    moving = 1'b1;
                    while (moving) begin
                        left = 2 * node + 1;
                        best = node;
                        if (left < heap_fill &&
                            heap_model[best].urgency < heap_model[left].urgency)
                            best = left;
                        if (left + 1 < heap_fill &&
                            heap_model[best].urgency < heap_model[left + 1].urgency)
                            best = left + 1;
                        moving = (best != node);
                        if (moving) begin
                            spare            = heap_model[best];
                            heap_model[best] = heap_model[node];
                            heap_model[node] = spare;
                            node             = best;
                        end
                    end
                end
            end
            outcome.rec = heap_model[0];
            heap_model[0] = heap_model[heap_fill - 1];
            heap_fill--;
            outcome.status = mhpe_pkg::ST_EXTRACTED;
        end
        outcome.count = heap_fill[mhpe_pkg::CNT_W-1:0];
        return outcome;
    endfunction

    // Random record; half of the urgencies come from a narrow range so that
    // ties are common and the tie rule is exercised.
    function automatic mhpe_pkg::rec_t random_record();
        mhpe_pkg::rec_t rec;
        rec.id      = 16'($urandom_range(0, 16'hFFFF));
        rec.age     = 8'($urandom_range(0, 8'hFF));
        rec.urgency = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                                  : 8'($urandom_range(0, 8'hFF));
        return rec;
    endfunction

    // Presents one request and returns at the clock edge where it is taken.
    // The valid stays high into the next request when no gap is drawn, so it is
    // never lowered and raised within the same time step.
    task automatic send_request(logic kind, mhpe_pkg::rec_t rec);
        int gap;
        gap = feed_steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rec;
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_outcome(kind, rec));
        requests_sent++;
    endtask

    task automatic compare_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         results_seen, field, want, got);
        end
    endtask

    // Result sink: takes each result, checks it against the oldest prediction,
    // then stalls for a random number of cycles before taking the next one.
    initial begin : result_sink
        mhpe_pkg::res_t want;
        int   stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: no request outstanding, got status %0d data 0x%0h",
                                 results_seen, m_tuser, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", want.status, m_tuser);
                    compare_field("out_id", want.rec.id, m_tdata[15:0]);
                    compare_field("out_age", want.rec.age, m_tdata[23:16]);
                    compare_field("out_urgency", want.rec.urgency, m_tdata[31:24]);
                    compare_field("entry_count", want.count,
                                  m_tdata[mhpe_pkg::REC_W+mhpe_pkg::CNT_W-1:mhpe_pkg::REC_W]);
                    compare_field("padding", 0,
                                  m_tdata[mhpe_pkg::OUT_W-1:mhpe_pkg::REC_W+mhpe_pkg::CNT_W]);
                end
                if (results_seen % 64 == 0)
                    sink_steady = ($urandom_range(0, 3) == 0);
                stall = sink_steady ? 0 : $urandom_range(0, 7);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // An extract on an empty store reports empty with zero fields; the load
    // fields of an extract request carry noise and must be ignored.
    task automatic test_empty_extract();
        send_request(mhpe_pkg::REQ_EXTRACT, random_record());
        send_request(mhpe_pkg::REQ_EXTRACT, '1);
        send_request(mhpe_pkg::REQ_EXTRACT, '0);
    endtask

    // Loads all-zero, all-one and alternating bit patterns, then takes them out
    // and extracts once more from the emptied store.
    task automatic test_field_extremes();
        send_request(mhpe_pkg::REQ_LOAD, '0);
        send_request(mhpe_pkg::REQ_LOAD, '1);
        send_request(mhpe_pkg::REQ_LOAD, {8'h55, 8'hAA, 16'h5555});
        send_request(mhpe_pkg::REQ_LOAD, {8'hAA, 8'h55, 16'hAAAA});
        repeat (5) send_request(mhpe_pkg::REQ_EXTRACT, random_record());
    endtask

    // Equal urgencies must keep their array order; one higher record is loaded
    // in the middle so that the rebuild has to move it past the tied ones.
    task automatic test_equal_urgency();
        send_request(mhpe_pkg::REQ_LOAD, {8'h40, 8'd10, 16'h0001});
        send_request(mhpe_pkg::REQ_LOAD, {8'h40, 8'd20, 16'h0002});
        send_request(mhpe_pkg::REQ_LOAD, {8'h41, 8'd30, 16'h0003});
        send_request(mhpe_pkg::REQ_LOAD, {8'h40, 8'd40, 16'h0004});
        send_request(mhpe_pkg::REQ_LOAD, {8'h40, 8'd50, 16'h0005});
        repeat (5) send_request(mhpe_pkg::REQ_EXTRACT, random_record());
    endtask

    // Fills the store, has further loads rejected, then drains it past empty.
    task automatic test_full_store();
        while (heap_fill < mhpe_pkg::CAPACITY)
            send_request(mhpe_pkg::REQ_LOAD, random_record());
        repeat (3) send_request(mhpe_pkg::REQ_LOAD, random_record());
        while (heap_fill > 0) send_request(mhpe_pkg::REQ_EXTRACT, random_record());
        send_request(mhpe_pkg::REQ_EXTRACT, random_record());
    endtask

    // Random traffic in phases: fill runs that may end on rejected loads, drain runs
    // that may end on empty extracts, and mixed runs with a random load bias. Each
    // phase draws whether the sender idles at all.
    task automatic test_random_traffic();
        int span;
        int load_bias;
        while (requests_sent < TOTAL_REQUESTS) begin
            feed_steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0: begin
                    while (heap_fill < mhpe_pkg::CAPACITY)
                        send_request(mhpe_pkg::REQ_LOAD, random_record());
                    repeat ($urandom_range(0, 2))
                        send_request(mhpe_pkg::REQ_LOAD, random_record());
                end
                1: begin
                    while (heap_fill > 0)
                        send_request(mhpe_pkg::REQ_EXTRACT, random_record());
                    repeat ($urandom_range(0, 2))
                        send_request(mhpe_pkg::REQ_EXTRACT, random_record());
                end
                default: begin
                    span = $urandom_range(10, 60);
                    load_bias = $urandom_range(30, 70);
                    repeat (span)
                        send_request(($urandom_range(0, 99) < load_bias)
                                         ? mhpe_pkg::REQ_LOAD : mhpe_pkg::REQ_EXTRACT,
                                     random_record());
                end
            endcase
        end
        feed_steady = 1'b0;
    endtask

    // Main sequence: reset once, run the tests in turn, wait for every result
    // and a settling period, then report.
    initial begin
        heap_fill     = 0;
        mismatches    = 0;
        results_seen  = 0;
        requests_sent = 0;
        feed_steady   = 1'b0;
        sink_steady   = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= mhpe_pkg::REQ_LOAD;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_extract();
        test_field_extremes();
        test_equal_urgency();
        test_full_store();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
